// ===== hdl/checksum_frame_receiver_macros.svh =====
// ---------------------------------------------------------------------------
// checksum_frame_receiver_macros
// assertion macros used by the checksum frame receiver checker
// ---------------------------------------------------------------------------
`ifndef CHECKSUM_FRAME_RECEIVER_MACROS_SVH
`define CHECKSUM_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication
`define CFR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cfr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfr_pkg
// types and constants of the checksum frame receiver
// ---------------------------------------------------------------------------
package cfr_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

    localparam logic [7:0]  START_BYTE_RST    = 8'd0;
    localparam logic [7:0]  MAX_LENGTH_RST    = 8'd255;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;
    localparam logic [1:0] KIND_TIMEOUT = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } cfr_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [8:0] byte_index;
        logic [7:0] data_byte;
        logic [8:0] frame_length;
        logic       last;
    } cfr_out_t;

endpackage

// ===== hdl/checksum_frame_receiver.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// checksum_frame_receiver
// serial deframer with start byte, length field, 8-bit checksum and timeout
// ---------------------------------------------------------------------------
// Takes one command transfer per clock while ready: start, received byte
// or tick. The frame state updates in the cycle of the transfer and the
// up to two results it causes are registered into a four-entry result
// queue, from which m_data shows the oldest. The queue drains one result
// per cycle while m_ready is high; the input is ready while at least two
// entries are free, which sustains one input transfer per cycle as long as
// the output side keeps up (a frame-end byte yields two results).
// There is no clearing pass after reset.
// ---------------------------------------------------------------------------
module checksum_frame_receiver (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cfr_pkg::cfr_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output cfr_pkg::cfr_out_t                   m_data,
    input  logic                                cfg_we,
    input  logic [cfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cfr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import cfr_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HUNT = 2'd1;
    localparam logic [1:0] PH_RECV = 2'd2;

    localparam int QDepth = 4;
    localparam int PtrW   = $clog2(QDepth);
    localparam int CntW   = $clog2(QDepth + 1);
    localparam logic [CntW-1:0] ReadyMax = CntW'(QDepth - 2);

    logic [7:0]  start_byte_reg;
    logic [7:0]  max_length_reg;
    logic [15:0] timeout_ticks_reg;

    logic [1:0]  phase_reg,    phase_next;
    logic [8:0]  position_reg, position_next;
    logic [8:0]  end_index_reg, end_index_next;
    logic [7:0]  sum_reg,      sum_next;
    logic [16:0] elapsed_reg,  elapsed_next;

    cfr_out_t            queue_reg [QDepth];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     count_reg,  count_next;

    logic        in_xfer;
    logic        out_xfer;
    logic [7:0]  sum_add;
    logic [8:0]  end_sel;
    logic [16:0] elapsed_inc;
    cfr_out_t    res0;
    cfr_out_t    res1;
    logic [1:0]  n_res;

    assign s_ready  = (count_reg <= ReadyMax);
    assign in_xfer  = s_valid && s_ready;
    assign m_valid  = (count_reg != '0);
    assign out_xfer = m_valid && m_ready;
    assign m_data   = queue_reg[rd_ptr_reg];

    assign sum_add = sum_reg + s_data.rx_byte;
    assign end_sel = (position_reg == 9'd1 && s_data.rx_byte < max_length_reg) ?
                     ({1'b0, s_data.rx_byte} + 9'd2) : end_index_reg;
    assign elapsed_inc = (elapsed_reg <= {1'b0, timeout_ticks_reg}) ?
                         (elapsed_reg + 17'd1) : elapsed_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg    <= START_BYTE_RST;
            max_length_reg    <= MAX_LENGTH_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_START_BYTE:    start_byte_reg    <= cfg_wdata[7:0];
                CFG_MAX_LENGTH:    max_length_reg    <= cfg_wdata[7:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // frame state and results of the current transfer
    always_comb begin
        phase_next     = phase_reg;
        position_next  = position_reg;
        end_index_next = end_index_reg;
        sum_next       = sum_reg;
        elapsed_next   = elapsed_reg;
        res0           = '0;
        res1           = '0;
        n_res          = 2'd0;
        if (in_xfer) begin
            case (s_data.command)
                CMD_START: begin
                    phase_next     = PH_HUNT;
                    elapsed_next   = '0;
                    position_next  = '0;
                    end_index_next = {1'b0, max_length_reg};
                    sum_next       = '0;
                end
                CMD_BYTE: begin
                    case (phase_reg)
                        PH_HUNT: begin
                            if (s_data.rx_byte == start_byte_reg) begin
                                sum_next       = start_byte_reg;
                                position_next  = '0;
                                end_index_next = {1'b0, max_length_reg};
                                phase_next     = PH_RECV;
                            end
                        end
                        PH_RECV: begin
                            sum_next        = sum_add;
                            end_index_next  = end_sel;
                            res0.kind       = KIND_DATA;
                            res0.byte_index = position_reg;
                            res0.data_byte  = s_data.rx_byte;
                            if (position_reg >= end_sel) begin
                                res0.last  = 1'b0;
                                res1.last  = 1'b1;
                                if (sum_add == 8'd0) begin
                                    res1.kind         = KIND_GOOD;
                                    res1.frame_length = end_sel;
                                end else begin
                                    res1.kind = KIND_BAD;
                                end
                                n_res      = 2'd2;
                                phase_next = PH_IDLE;
                            end else begin
                                res0.last     = 1'b1;
                                n_res         = 2'd1;
                                position_next = position_reg + 9'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_TICK: begin
                    if (phase_reg != PH_IDLE) begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc > {1'b0, timeout_ticks_reg}) begin
                            res0.kind  = KIND_TIMEOUT;
                            res0.last  = 1'b1;
                            n_res      = 2'd1;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PtrW'(n_res);
        rd_ptr_next = rd_ptr_reg + PtrW'(out_xfer);
        count_next  = count_reg + CntW'(n_res) - CntW'(out_xfer);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            position_reg  <= '0;
            end_index_reg <= '0;
            sum_reg       <= '0;
            elapsed_reg   <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end else begin
            phase_reg     <= phase_next;
            position_reg  <= position_next;
            end_index_reg <= end_index_next;
            sum_reg       <= sum_next;
            elapsed_reg   <= elapsed_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
        end
    end

    // result queue storage
    always_ff @(posedge aclk) begin
        if (n_res != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (n_res == 2'd2) begin
            queue_reg[wr_ptr_reg + PtrW'(1)] <= res1;
        end
    end

endmodule

// ===== hdl/cfr_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfr_checker
// port-level checks of the checksum frame receiver, bound to the top level
// ---------------------------------------------------------------------------
`include "checksum_frame_receiver_macros.svh"

module cfr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input cfr_pkg::cfr_in_t               s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input cfr_pkg::cfr_out_t              m_data
);
    import cfr_pkg::*;

    // stalled result transfer holds
    `CFR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // a data byte that is not last is followed at once by the frame verdict
    `CFR_ASSERT_NEXT(a_verdict_follows, aclk, aresetn, m_valid && m_ready && m_data.kind == KIND_DATA && !m_data.last, m_valid && (m_data.kind == KIND_GOOD || m_data.kind == KIND_BAD) && m_data.last, "frame end without verdict")

    // only a good frame reports a length
    `CFR_ASSERT_NOW(a_length_only_good, aclk, aresetn, m_valid && m_data.kind != KIND_GOOD, m_data.frame_length == 9'd0, "length on a non-good result")

    // a start command on an empty queue gives no result
    `CFR_ASSERT_NEXT(a_start_silent, aclk, aresetn, !m_valid && s_valid && s_ready && s_data.command == CMD_START, !m_valid, "result after start command")

endmodule

bind checksum_frame_receiver cfr_checker u_cfr_checker (.*);
